>>> sv/bcrp_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the connection-request parser.
// No dependencies; imported by every module of the block.
package bcrp_pkg;

   localparam int unsigned BYTE_WIDTH   = 8;
   localparam int unsigned POS_WIDTH    = 6;
   localparam int unsigned ADDR_WIDTH   = 48;
   localparam int unsigned RSP_WIDTH    = 104;
   localparam int unsigned FIFO_DEPTH   = 4;

   localparam logic [POS_WIDTH-1:0]  FULL_BYTES       = 6'd36;
   localparam logic [3:0]            PDU_TYPE_CONNECT = 4'h5;
   localparam logic [7:0]            CONNECT_LEN      = 8'd34;
   localparam logic [15:0]           INTERVAL_MIN     = 16'd6;
   localparam logic [15:0]           INTERVAL_MAX     = 16'd3200;

   // byte positions inside the PDU
   localparam logic [POS_WIDTH-1:0]  POS_HEADER   = 6'd0;
   localparam logic [POS_WIDTH-1:0]  POS_LENGTH   = 6'd1;
   localparam logic [POS_WIDTH-1:0]  POS_INITA    = 6'd2;
   localparam logic [POS_WIDTH-1:0]  POS_ADVA     = 6'd8;
   localparam logic [POS_WIDTH-1:0]  POS_AA       = 6'd14;
   localparam logic [POS_WIDTH-1:0]  POS_CRC      = 6'd18;
   localparam logic [POS_WIDTH-1:0]  POS_WSIZE    = 6'd21;
   localparam logic [POS_WIDTH-1:0]  POS_WOFFSET  = 6'd22;
   localparam logic [POS_WIDTH-1:0]  POS_INTERVAL = 6'd24;
   localparam logic [POS_WIDTH-1:0]  POS_HOP      = 6'd35;

   // configuration register indexes
   localparam logic CSR_TARGET_ADDRESS = 1'b0;
   localparam logic CSR_TARGET_ENABLE  = 1'b1;

   typedef enum logic [2:0] {
      STATUS_OK        = 3'd0,
      STATUS_WRONG_TYPE = 3'd1,
      STATUS_BAD_LENGTH = 3'd2,
      STATUS_TRUNCATED  = 3'd3,
      STATUS_INTERVAL   = 3'd4,
      STATUS_MISMATCH   = 3'd5
   } status_type;

   // one classified byte, front to back
   typedef struct packed {
      logic [BYTE_WIDTH-1:0] rx_byte;
      logic [POS_WIDTH-1:0]  pos;
      logic                  cap;    // byte lies inside the first 36
      logic                  first;  // restart before capture
      logic                  last;   // result due after capture
      logic                  full;   // 36 bytes counted including this one
   } entry_type;

   typedef struct packed {
      logic [3:0]  pdu_type;
      logic [7:0]  length;
      logic        init_match;
      logic        adv_match;
      logic [31:0] link_address;
      logic [23:0] crc_seed;
      logic [7:0]  window_size;
      logic [15:0] window_offset;
      logic [15:0] link_interval;
      logic [4:0]  hop_increment;
   } cap_state_type;

   localparam cap_state_type CAP_RESET = '{
      pdu_type:       4'd0,
      length:         8'd0,
      init_match:     1'b1,
      adv_match:      1'b1,
      link_address:   32'd0,
      crc_seed:       24'd0,
      window_size:    8'd0,
      window_offset:  16'd0,
      link_interval:  16'd0,
      hop_increment:  5'd0
   };

endpackage

>>> sv/bcrp_front.sv
`timescale 1ns / 1ps
// Input side: takes PDU bytes, tracks the byte position and tags each byte.
// Depends on bcrp_pkg.
module bcrp_front (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_tvalid,
   output logic                      req_tready,
   input  logic [7:0]                req_tdata,   // rx_byte
   input  logic                      req_tuser,   // first_byte
   input  logic                      req_tlast,   // last_byte
   input  logic                      fifo_full,
   output logic                      push,
   output bcrp_pkg::entry_type       push_entry
);
   import bcrp_pkg::*;

   logic [POS_WIDTH-1:0] pos_ff, pos_in;
   logic [POS_WIDTH-1:0] pos_eff, pos_next;
   logic                 cap;

   assign req_tready = !fifo_full;
   assign push       = req_tvalid && !fifo_full;

   always_comb begin
      pos_eff  = req_tuser ? POS_HEADER : pos_ff;
      cap      = pos_eff < FULL_BYTES;
      pos_next = cap ? pos_eff + 1'b1 : pos_eff;

      push_entry.rx_byte = req_tdata;
      push_entry.pos     = pos_eff;
      push_entry.cap     = cap;
      push_entry.first   = req_tuser;
      push_entry.last    = req_tlast;
      push_entry.full    = pos_next == FULL_BYTES;

      pos_in = pos_ff;
      if (push) begin
         pos_in = req_tlast ? POS_HEADER : pos_next;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff <= '0;
      end else begin
         pos_ff <= pos_in;
      end
   end

endmodule

>>> sv/bcrp_fifo.sv
`timescale 1ns / 1ps
// Short show-ahead queue of tagged bytes between front and back.
// Depends on bcrp_pkg.
module bcrp_fifo #(
   parameter int unsigned DEPTH = bcrp_pkg::FIFO_DEPTH
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          push,
   input  bcrp_pkg::entry_type           push_entry,
   input  logic                          pop,
   output logic                          head_valid,
   output bcrp_pkg::entry_type           head_entry,
   output logic                          full,
   output logic [$clog2(DEPTH+1)-1:0]    level
);
   import bcrp_pkg::*;

   localparam int unsigned PTR_WIDTH = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int unsigned CNT_WIDTH = $clog2(DEPTH+1);
   localparam logic [PTR_WIDTH-1:0] LAST_PTR = PTR_WIDTH'(DEPTH - 1);
   localparam logic [CNT_WIDTH-1:0] DEPTH_CNT = CNT_WIDTH'(DEPTH);

   entry_type            mem [DEPTH];
   logic [PTR_WIDTH-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_WIDTH-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_WIDTH-1:0] count_ff, count_in;
   logic                 do_push, do_pop;

   assign full       = count_ff == DEPTH_CNT;
   assign head_valid = count_ff != '0;
   assign head_entry = mem[rd_ptr_ff];
   assign level      = count_ff;
   assign do_push    = push && !full;
   assign do_pop     = pop && head_valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + 1'b1;
      end
      case ({do_push, do_pop})
         2'b10:   count_in = count_ff + 1'b1;
         2'b01:   count_in = count_ff - 1'b1;
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem[wr_ptr_ff] <= push_entry;
      end
   end

endmodule

>>> sv/bcrp_back.sv
`timescale 1ns / 1ps
// Back end: applies tagged bytes to the captured fields, judges the packet
// on its last byte and holds the result register. Depends on bcrp_pkg.
module bcrp_back (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  head_valid,
   input  bcrp_pkg::entry_type                   head_entry,
   output logic                                  pop,
   input  logic [bcrp_pkg::ADDR_WIDTH-1:0]       target_address,
   input  logic                                  target_enable,
   output logic                                  rsp_tvalid,
   input  logic                                  rsp_tready,
   output logic [bcrp_pkg::RSP_WIDTH-1:0]        rsp_tdata
);
   import bcrp_pkg::*;

   cap_state_type           state_ff, state_in;
   cap_state_type           nxt;
   logic                    rsp_valid_ff, rsp_valid_in;
   logic [RSP_WIDTH-1:0]    rsp_data_ff, rsp_data_in;
   logic [2:0]              addr_idx;
   logic [7:0]              tgt_byte;
   logic [7:0]              b;
   logic [POS_WIDTH-1:0]    pos;
   status_type              status;

   assign b   = head_entry.rx_byte;
   assign pos = head_entry.pos;

   // a last byte may only leave the queue once the result register is free
   assign pop = head_valid && (!head_entry.last || !rsp_valid_ff || rsp_tready);

   always_comb begin
      addr_idx = (pos < POS_ADVA) ? 3'(pos - POS_INITA) : 3'(pos - POS_ADVA);
      case (addr_idx)
         3'd0:    tgt_byte = target_address[7:0];
         3'd1:    tgt_byte = target_address[15:8];
         3'd2:    tgt_byte = target_address[23:16];
         3'd3:    tgt_byte = target_address[31:24];
         3'd4:    tgt_byte = target_address[39:32];
         3'd5:    tgt_byte = target_address[47:40];
         default: tgt_byte = 8'd0;
      endcase
   end

   always_comb begin
      nxt = head_entry.first ? CAP_RESET : state_ff;
      if (head_entry.cap) begin
         if (pos == POS_HEADER) begin
            nxt.pdu_type = b[3:0];
         end else if (pos == POS_LENGTH) begin
            nxt.length = b;
         end else if (pos inside {[POS_INITA:POS_ADVA-1]}) begin
            if (b != tgt_byte) nxt.init_match = 1'b0;
         end else if (pos inside {[POS_ADVA:POS_AA-1]}) begin
            if (b != tgt_byte) nxt.adv_match = 1'b0;
         end else begin
            case (pos)
               POS_AA:           nxt.link_address[7:0]     = b;
               POS_AA + 6'd1:    nxt.link_address[15:8]    = b;
               POS_AA + 6'd2:    nxt.link_address[23:16]   = b;
               POS_AA + 6'd3:    nxt.link_address[31:24]   = b;
               POS_CRC:          nxt.crc_seed[7:0]         = b;
               POS_CRC + 6'd1:   nxt.crc_seed[15:8]        = b;
               POS_CRC + 6'd2:   nxt.crc_seed[23:16]       = b;
               POS_WSIZE:        nxt.window_size           = b;
               POS_WOFFSET:      nxt.window_offset[7:0]    = b;
               POS_WOFFSET+6'd1: nxt.window_offset[15:8]   = b;
               POS_INTERVAL:     nxt.link_interval[7:0]    = b;
               POS_INTERVAL+6'd1:nxt.link_interval[15:8]   = b;
               POS_HOP:          nxt.hop_increment         = b[4:0];
               default:          ;
            endcase
         end
      end
   end

   always_comb begin
      if (nxt.pdu_type != PDU_TYPE_CONNECT) begin
         status = STATUS_WRONG_TYPE;
      end else if (nxt.length != CONNECT_LEN) begin
         status = STATUS_BAD_LENGTH;
      end else if (!head_entry.full) begin
         status = STATUS_TRUNCATED;
      end else if (nxt.link_interval < INTERVAL_MIN || nxt.link_interval > INTERVAL_MAX) begin
         status = STATUS_INTERVAL;
      end else if (target_enable && !nxt.init_match && !nxt.adv_match) begin
         status = STATUS_MISMATCH;
      end else begin
         status = STATUS_OK;
      end
   end

   always_comb begin
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;
      if (pop) begin
         state_in = head_entry.last ? CAP_RESET : nxt;
         if (head_entry.last) begin
            rsp_valid_in = 1'b1;
            rsp_data_in  = {nxt.hop_increment, nxt.link_interval, nxt.window_offset,
                            nxt.window_size, nxt.crc_seed, nxt.link_address, status};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= CAP_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule

>>> sv/ble_connect_request_parser_core.sv
`timescale 1ns / 1ps
// Connection-request PDU parser, top level. Takes one byte per cycle while the queue has room.
// The last byte is written into the queue when it is taken; once it reaches the
// head and is popped, it goes straight into the result register that drives rsp_tvalid.
// Throughput: one byte per cycle; while a result waits, bytes up to the next
// last byte keep flowing, then the four-entry queue fills and req_tready drops.
// Reset (synchronous, active high) empties the queue and clears capture state.
module ble_connect_request_parser_core #(
   parameter int unsigned FIFO_DEPTH = bcrp_pkg::FIFO_DEPTH
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_tvalid,
   output logic                                 req_tready,
   input  logic [7:0]                           req_tdata,   // rx_byte
   input  logic                                 req_tuser,   // first_byte
   input  logic                                 req_tlast,   // last_byte
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   // status, link address, crc seed, window_size, window_offset,
   // link interval, hop_increment (lowest bit up)
   output logic [bcrp_pkg::RSP_WIDTH-1:0]       rsp_tdata,
   input  logic                                 csr_we,
   input  logic                                 csr_addr,
   input  logic [bcrp_pkg::ADDR_WIDTH-1:0]      csr_wdata
);
   import bcrp_pkg::*;

   localparam int unsigned CNT_WIDTH = $clog2(FIFO_DEPTH+1);

   logic [ADDR_WIDTH-1:0]  target_address_ff;
   logic                   target_enable_ff;
   logic                   fifo_full, push, pop, head_valid;
   entry_type              push_entry, head_entry;
   logic [CNT_WIDTH-1:0]   fifo_level;

   always_ff @(posedge clock) begin
      if (reset) begin
         target_address_ff <= '0;
         target_enable_ff  <= 1'b0;
      end else if (csr_we) begin
         case (csr_addr)
            CSR_TARGET_ADDRESS: target_address_ff <= csr_wdata;
            CSR_TARGET_ENABLE:  target_enable_ff  <= csr_wdata[0];
            default:            ;
         endcase
      end
   end

   bcrp_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .req_tlast  (req_tlast),
      .fifo_full  (fifo_full),
      .push       (push),
      .push_entry (push_entry)
   );

   bcrp_fifo #(.DEPTH(FIFO_DEPTH)) u_fifo (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .pop        (pop),
      .head_valid (head_valid),
      .head_entry (head_entry),
      .full       (fifo_full),
      .level      (fifo_level)
   );

   bcrp_back u_back (
      .clock          (clock),
      .reset          (reset),
      .head_valid     (head_valid),
      .head_entry     (head_entry),
      .pop            (pop),
      .target_address (target_address_ff),
      .target_enable  (target_enable_ff),
      .rsp_tvalid     (rsp_tvalid),
      .rsp_tready     (rsp_tready),
      .rsp_tdata      (rsp_tdata)
   );

   // a popped last byte always lands in the result register
   a_last_gives_result: assert property (@(posedge clock) disable iff (reset)
      (pop && head_entry.last) |=> rsp_tvalid)
      else $error("last byte popped without a result");

   // an accepted byte is in the queue on the next cycle
   a_push_lands: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> (fifo_level != '0))
      else $error("accepted transaction lost from queue");

   // queue never overfills, and ready drops only when it is full
   a_level_bound: assert property (@(posedge clock) disable iff (reset)
      (fifo_level <= CNT_WIDTH'(FIFO_DEPTH)) &&
      (req_tready == (fifo_level != CNT_WIDTH'(FIFO_DEPTH))))
      else $error("queue level out of range");

   // a stalled result is not overwritten by a new one
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tready) |-> !(pop && head_entry.last))
      else $error("result overwritten while stalled");

endmodule
